FILE: hdl/arp_pkg.sv
package arp_pkg;

  localparam int unsigned DELAY_DEPTH = 3;
  localparam logic [15:0] RANGE_MAX_RST = 16'd200;

  // character codes of the sensor stream
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_K     = 8'h6B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic signed [31:0] S32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] EMPTY_MRK = -32'sd1;

  typedef struct packed {
    logic signed [31:0] distance;
    logic signed [31:0] angle;
  } rec_t;

  typedef struct packed {
    logic        valid;
    logic [30:0] distance;
    logic [31:0] angle;
  } point_t;

  // saturating negate
  function automatic logic signed [31:0] sat_neg(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == S32_MIN) r = S32_MAX;
    else r = -v;
    return r;
  endfunction

  // 10 * acc + (b - 48), saturated to 32 bits
  function automatic logic signed [31:0] mac10(input logic signed [31:0] acc,
                                               input logic [7:0] b);
    logic signed [36:0] ext;
    logic signed [36:0] add;
    logic signed [36:0] sum;
    logic signed [31:0] r;
    ext = 37'(acc);
    add = $signed({29'd0, b}) - $signed({29'd0, CH_ZERO});
    sum = (ext <<< 3) + (ext <<< 1) + add;
    if (sum > 37'(S32_MAX)) r = S32_MAX;
    else if (sum < 37'(S32_MIN)) r = S32_MIN;
    else r = sum[31:0];
    return r;
  endfunction

endpackage

FILE: hdl/arp_if.sv
interface arp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface arp_point_if;
  logic               valid;
  logic               ready;
  logic        [30:0] point_dist;
  logic signed [31:0] point_angle;

  modport source (output valid, output point_dist, output point_angle, input ready);
  modport sink (input valid, input point_dist, input point_angle, output ready);
endinterface

FILE: hdl/arp_accum.sv
module arp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output arp_pkg::rec_t     rec
);

  logic signed [31:0] angle_r, angle_nxt;
  logic signed [31:0] dist_r, dist_nxt;
  logic               ang_sel_r, ang_sel_nxt;
  logic               neg_r, neg_nxt;

  logic               is_nl, is_sp, is_skip, neg_now;
  logic signed [31:0] angle_v, dist_v;

  always_comb begin
    is_nl   = (rx_byte == arp_pkg::CH_NL);
    is_sp   = (rx_byte == arp_pkg::CH_SPACE);
    is_skip = (rx_byte == arp_pkg::CH_S) || (rx_byte == arp_pkg::CH_K) ||
              (rx_byte == arp_pkg::CH_M) || (rx_byte == arp_pkg::CH_DOT);
    neg_now = (is_nl || is_sp) && neg_r;
    angle_v = (neg_now && ang_sel_r) ? arp_pkg::sat_neg(angle_r) : angle_r;
    dist_v  = (neg_now && !ang_sel_r) ? arp_pkg::sat_neg(dist_r) : dist_r;

    push         = en && is_nl;
    rec.distance = dist_v;
    rec.angle    = angle_v;

    angle_nxt   = angle_v;
    dist_nxt    = dist_v;
    ang_sel_nxt = ang_sel_r;
    neg_nxt     = neg_now ? 1'b0 : neg_r;

    if (is_skip) begin
      angle_nxt = angle_r;
      dist_nxt  = dist_r;
      neg_nxt   = neg_r;
    end else if (is_nl) begin
      angle_nxt = '0;
      dist_nxt  = '0;
    end else if (!is_sp) begin
      case (rx_byte)
        arp_pkg::CH_A:     ang_sel_nxt = 1'b1;
        arp_pkg::CH_D:     ang_sel_nxt = 1'b0;
        arp_pkg::CH_MINUS: neg_nxt = 1'b1;
        default: begin
          if (ang_sel_r) angle_nxt = arp_pkg::mac10(angle_r, rx_byte);
          else dist_nxt = arp_pkg::mac10(dist_r, rx_byte);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r   <= '0;
      dist_r    <= '0;
      ang_sel_r <= 1'b1;
      neg_r     <= 1'b0;
    end else if (en) begin
      angle_r   <= angle_nxt;
      dist_r    <= dist_nxt;
      ang_sel_r <= ang_sel_nxt;
      neg_r     <= neg_nxt;
    end
  end

endmodule

FILE: hdl/arp_delay.sv
module arp_delay #(
  parameter int unsigned DELAY_DEPTH = arp_pkg::DELAY_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  arp_pkg::rec_t     rec,
  input  logic [15:0]       range_max,
  output arp_pkg::point_t   pt
);

  localparam int unsigned TOP = DELAY_DEPTH - 1;

  arp_pkg::rec_t line_r [DELAY_DEPTH];
  arp_pkg::rec_t mid_nxt;

  logic signed [32:0] lim;
  logic signed [32:0] sum;
  logic signed [32:0] half;
  logic               occupied, fix;

  always_comb begin
    lim      = $signed({17'd0, range_max}) - 33'sd2;
    occupied = (line_r[0].distance != arp_pkg::EMPTY_MRK);
    fix      = occupied && (33'(line_r[TOP].distance) >= lim) && (33'(rec.distance) < lim);
    sum      = 33'(line_r[0].distance) + 33'(rec.distance);
    // divide by two rounding toward zero
    half     = (sum + $signed({32'd0, sum[32]})) >>> 1;

    // newest entry moves down one place, smoothed when fix holds
    mid_nxt = line_r[TOP];
    if (fix) mid_nxt.distance = half[31:0];

    pt.valid    = occupied && (line_r[0].distance > 32'sd0);
    pt.distance = line_r[0].distance[30:0];
    pt.angle    = line_r[0].angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        line_r[i].distance <= arp_pkg::EMPTY_MRK;
        line_r[i].angle    <= arp_pkg::EMPTY_MRK;
      end
    end else if (push) begin
      for (int i = 0; i < TOP - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[TOP-1] <= mid_nxt;
      line_r[TOP]   <= rec;
    end
  end

endmodule

FILE: hdl/ascii_range_record_parser_top.sv
// Path: an accepted byte goes to the input register, then its point (if any) to
//   the result register, which drives out_bus.
// Throughput: one byte per cycle; in_bus.ready only drops while a result is held,
//   the sink stalls and the input register is full.
// Reset (rst_n low, synchronous): accumulators 0, angle selected, no negate,
//   delay line all -1 (empty), range limit 200, both pipeline registers empty.
module ascii_range_record_parser_top #(
  parameter int unsigned DELAY_DEPTH = arp_pkg::DELAY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  arp_byte_if.sink           in_bus,
  arp_point_if.source        out_bus,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  logic [15:0]     range_max_r;
  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            out_valid_r;
  logic [30:0]     out_dist_r;
  logic [31:0]     out_angle_r;

  logic            adv, step, push;
  arp_pkg::rec_t   rec;
  arp_pkg::point_t pt;

  assign adv  = !out_valid_r || out_bus.ready;
  assign step = s1_valid_r && adv;
  assign in_bus.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) range_max_r <= arp_pkg::RANGE_MAX_RST;
    else if (cfg_we) range_max_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready) s1_byte_r <= in_bus.rx_byte;
  end

  arp_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (step),
    .rx_byte (s1_byte_r),
    .push    (push),
    .rec     (rec)
  );

  arp_delay #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .rec       (rec),
    .range_max (range_max_r),
    .pt        (pt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= push && pt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r  <= pt.distance;
      out_angle_r <= pt.angle;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.point_dist  = out_dist_r;
  assign out_bus.point_angle = out_angle_r;

  // only a newline request can produce a point
  a_no_point_without_nl: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_byte_r != arp_pkg::CH_NL) |=> !out_valid_r)
    else $error("point emitted for a non-newline request");

  // emitted distances are always positive
  a_dist_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_dist_r != '0))
    else $error("point with zero distance");

  // an empty input register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_bus.ready)
    else $error("input stalled with empty input register");

  // a held result stays put while the sink stalls
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_valid_r && $stable(out_dist_r)
                                         && $stable(out_angle_r)))
    else $error("held result changed under stall");

endmodule
